>>> src/lfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfm_pkg
// Shared types, register codes and reset values of the link fault monitor.
// ----------------------------------------------------------------------------
package lfm_pkg;

	localparam int NUM_ITEMS       = 4;
	localparam int IRQ_LINES_DEF   = 16;
	localparam int COUNT_BITS_DEF  = 8;

	localparam int SYNC_W   = 4;
	localparam int IRQ_W    = 16;
	localparam int THR_W    = 8;
	localparam int ACT_W    = 2;
	localparam int STATUS_W = NUM_ITEMS * ACT_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Item order inside the packed fields
	localparam int ITEM_TX    = 0;
	localparam int ITEM_RX    = 1;
	localparam int ITEM_LEN   = 2;
	localparam int ITEM_OTHER = 3;

	typedef logic [ACT_W-1:0] action_t;

	localparam action_t ACT_NONE  = 2'd0;
	localparam action_t ACT_WARN  = 2'd1;
	localparam action_t ACT_RESET = 2'd2;
	localparam action_t ACT_SPARE = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MONITOR_ENABLE    = 3'd0,
		REG_TX_CHECK_ENABLE   = 3'd1,
		REG_ITEM_THRESHOLDS   = 3'd2,
		REG_ITEM_ACTIONS      = 3'd3,
		REG_SYNC_READY_LEVEL  = 3'd4,
		REG_LENGTH_ERROR_MASK = 3'd5
	} cfg_reg_t;

	localparam logic [31:0]       RST_THRESHOLDS = 32'h0303_0303;
	localparam logic [STATUS_W-1:0] RST_ACTIONS  = 8'h4A;
	localparam logic [SYNC_W-1:0] RST_SYNC_LEVEL = 4'd6;
	localparam logic [IRQ_W-1:0]  RST_LEN_MASK   = 16'h0003;

	// Per-item control handed to a check slice each tick
	typedef struct packed {
		logic             advance;
		logic             fail;
		logic [THR_W-1:0] threshold;
		action_t          action;
	} item_ctrl_t;

endpackage

>>> src/lfm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfm_if
// Handshake channels of the link fault monitor: tick, result and config.
// ----------------------------------------------------------------------------
interface lfm_tick_if;
	logic                          valid;
	logic                          ready;
	logic [lfm_pkg::SYNC_W-1:0]    rx_sync_state;
	logic                          tx_alive;
	logic                          rx_fsm_error;
	logic [lfm_pkg::IRQ_W-1:0]     irq_status;

	modport source (output valid, rx_sync_state, tx_alive, rx_fsm_error, irq_status,
		input ready);
	modport sink (input valid, rx_sync_state, tx_alive, rx_fsm_error, irq_status,
		output ready);
endinterface

interface lfm_result_if;
	logic                          valid;
	logic                          ready;
	logic [lfm_pkg::ACT_W-1:0]     current_action;
	logic                          action_changed;
	logic                          clear_irq;
	logic [lfm_pkg::STATUS_W-1:0]  item_status;

	modport source (output valid, current_action, action_changed, clear_irq, item_status,
		input ready);
	modport sink (input valid, current_action, action_changed, clear_irq, item_status,
		output ready);
endinterface

interface lfm_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [lfm_pkg::CFG_IDX_W-1:0]   reg_index;
	logic [lfm_pkg::CFG_DATA_W-1:0]  wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

>>> src/lfm_item.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfm_item
// One checked item: consecutive-fail counter and latched action status.
// ----------------------------------------------------------------------------
module lfm_item #(
	parameter int COUNT_BITS = lfm_pkg::COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lfm_pkg::item_ctrl_t  ctrl,
	output lfm_pkg::action_t     status_next
);

	localparam int CW = (COUNT_BITS > lfm_pkg::THR_W) ? COUNT_BITS : lfm_pkg::THR_W;
	localparam logic [CW-1:0] CNT_MAX = CW'((32'd1 << COUNT_BITS) - 32'd1);

	logic [COUNT_BITS-1:0] fail_count_q;
	lfm_pkg::action_t      status_q;

	logic [CW-1:0]         thr_sat;
	logic                  below;
	lfm_pkg::action_t      act_map;
	logic [COUNT_BITS-1:0] count_next;

	always_comb begin
		// saturate threshold to what the counter can hold
		thr_sat = (CW'(ctrl.threshold) > CNT_MAX) ? CNT_MAX : CW'(ctrl.threshold);
		below   = CW'(fail_count_q) < thr_sat;
		act_map = (ctrl.action == lfm_pkg::ACT_SPARE) ? lfm_pkg::ACT_RESET : ctrl.action;

		count_next  = fail_count_q;
		status_next = status_q;
		if (ctrl.advance) begin
			if (!ctrl.fail) begin
				count_next  = '0;
				status_next = lfm_pkg::ACT_NONE;
			end else if (below) begin
				count_next = fail_count_q + 1'b1;
			end else begin
				status_next = act_map;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count_q <= '0;
			status_q     <= lfm_pkg::ACT_NONE;
		end else begin
			fail_count_q <= count_next;
			status_q     <= status_next;
		end
	end

endmodule

>>> src/link_fault_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_fault_monitor
// Periodic link health monitor: PHY tx, PHY rx, MAC length and MAC other
// checks with consecutive-fail thresholds and a reported worst action.
// ----------------------------------------------------------------------------
// One health-check tick is taken per transfer on the tick channel, and one
// result comes out per tick, in order. A tick may be transferred in every
// cycle while the result channel is ready: the tick is captured in the input
// register, the four checks, counter updates and the worst-action select run
// combinationally from that register, and the result is held in the output
// register, from which it is offered on the result channel.
// Sustained throughput is one tick per clock, set by the combinational check
// logic feeding the output register; a stalled result channel backs up the
// input register and then the tick channel.
// Configuration is written through the cfg channel, which is always ready,
// and must only be written while no tick is in flight. With monitor_enable
// clear, ticks still produce results, but no counter or status moves.
// ----------------------------------------------------------------------------
module link_fault_monitor #(
	parameter int IRQ_LINES  = lfm_pkg::IRQ_LINES_DEF,
	parameter int COUNT_BITS = lfm_pkg::COUNT_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	lfm_cfg_if.sink      cfg,
	lfm_tick_if.sink     tick,
	lfm_result_if.source result
);

	localparam int IRQ_W = lfm_pkg::IRQ_W;
	// Lines of irq_status that are examined at all
	localparam logic [IRQ_W-1:0] LINE_MASK = (IRQ_LINES >= IRQ_W) ? {IRQ_W{1'b1}} :
		IRQ_W'((64'd1 << IRQ_LINES) - 64'd1);

	// ---------------- configuration registers ----------------
	logic                          monitor_enable_q;
	logic                          tx_check_enable_q;
	logic [31:0]                   thresholds_q;
	logic [lfm_pkg::STATUS_W-1:0]  actions_q;
	logic [lfm_pkg::SYNC_W-1:0]    sync_level_q;
	logic [IRQ_W-1:0]              len_mask_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			monitor_enable_q  <= 1'b0;
			tx_check_enable_q <= 1'b0;
			thresholds_q      <= lfm_pkg::RST_THRESHOLDS;
			actions_q         <= lfm_pkg::RST_ACTIONS;
			sync_level_q      <= lfm_pkg::RST_SYNC_LEVEL;
			len_mask_q        <= lfm_pkg::RST_LEN_MASK;
		end else if (cfg.valid) begin
			case (lfm_pkg::cfg_reg_t'(cfg.reg_index))
				lfm_pkg::REG_MONITOR_ENABLE:    monitor_enable_q  <= cfg.wdata[0];
				lfm_pkg::REG_TX_CHECK_ENABLE:   tx_check_enable_q <= cfg.wdata[0];
				lfm_pkg::REG_ITEM_THRESHOLDS:   thresholds_q      <= cfg.wdata;
				lfm_pkg::REG_ITEM_ACTIONS:      actions_q <= cfg.wdata[lfm_pkg::STATUS_W-1:0];
				lfm_pkg::REG_SYNC_READY_LEVEL:  sync_level_q <= cfg.wdata[lfm_pkg::SYNC_W-1:0];
				lfm_pkg::REG_LENGTH_ERROR_MASK: len_mask_q   <= cfg.wdata[IRQ_W-1:0];
				default: begin
					// unknown index: drop the write
				end
			endcase
		end
	end

	// ---------------- stage 1: input register ----------------
	logic                        valid_s1;
	logic [lfm_pkg::SYNC_W-1:0]  rx_sync_state_s1;
	logic                        tx_alive_s1;
	logic                        rx_fsm_error_s1;
	logic [IRQ_W-1:0]            irq_status_s1;

	logic valid_s2;
	logic load_s2;

	// Output slot frees when empty or when its result transfers this cycle
	assign load_s2    = valid_s1 && (!valid_s2 || result.ready);
	assign tick.ready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			rx_sync_state_s1 <= tick.rx_sync_state;
			tx_alive_s1      <= tick.tx_alive;
			rx_fsm_error_s1  <= tick.rx_fsm_error;
			irq_status_s1    <= tick.irq_status;
		end
	end

	// ---------------- checks ----------------
	logic                           sync_ready;
	logic [IRQ_W-1:0]               irq_seen;
	logic [lfm_pkg::NUM_ITEMS-1:0]  fail;
	logic                           advance;

	always_comb begin
		sync_ready = rx_sync_state_s1 >= sync_level_q;
		irq_seen   = irq_status_s1 & LINE_MASK;
		fail = '0;
		// tx and MAC checks only count once the receive side has synced
		fail[lfm_pkg::ITEM_TX]    = tx_check_enable_q && sync_ready && !tx_alive_s1;
		fail[lfm_pkg::ITEM_RX]    = rx_fsm_error_s1;
		fail[lfm_pkg::ITEM_LEN]   = sync_ready && (|(irq_seen & len_mask_q));
		fail[lfm_pkg::ITEM_OTHER] = sync_ready && (|(irq_seen & ~len_mask_q));
	end

	// State moves only when the tick leaves for the output register
	assign advance = load_s2 && monitor_enable_q;

	lfm_pkg::item_ctrl_t ctrl [lfm_pkg::NUM_ITEMS];
	lfm_pkg::action_t    status_next [lfm_pkg::NUM_ITEMS];

	for (genvar i = 0; i < lfm_pkg::NUM_ITEMS; i++) begin : g_item
		always_comb begin
			ctrl[i].advance   = advance;
			ctrl[i].fail      = fail[i];
			ctrl[i].threshold = thresholds_q[lfm_pkg::THR_W*i +: lfm_pkg::THR_W];
			ctrl[i].action    = actions_q[lfm_pkg::ACT_W*i +: lfm_pkg::ACT_W];
		end

		lfm_item #(
			.COUNT_BITS(COUNT_BITS)
		) u_item (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl[i]),
			.status_next (status_next[i])
		);
	end

	// ---------------- worst action and report ----------------
	lfm_pkg::action_t             reported_action_q;
	lfm_pkg::action_t             worst;
	logic [lfm_pkg::STATUS_W-1:0] status_pack;
	lfm_pkg::action_t             act_out;
	logic                         changed;
	logic                         clear_out;

	always_comb begin
		worst       = lfm_pkg::ACT_NONE;
		status_pack = '0;
		for (int i = 0; i < lfm_pkg::NUM_ITEMS; i++) begin
			if (status_next[i] > worst) begin
				worst = status_next[i];
			end
			status_pack[lfm_pkg::ACT_W*i +: lfm_pkg::ACT_W] = status_next[i];
		end
		if (monitor_enable_q) begin
			act_out   = worst;
			changed   = worst != reported_action_q;
			clear_out = fail[lfm_pkg::ITEM_LEN] || fail[lfm_pkg::ITEM_OTHER];
		end else begin
			// monitoring off: report the held action, flag nothing
			act_out   = reported_action_q;
			changed   = 1'b0;
			clear_out = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reported_action_q <= lfm_pkg::ACT_NONE;
		end else if (advance) begin
			reported_action_q <= worst;
		end
	end

	// ---------------- stage 2: result register ----------------
	lfm_pkg::action_t             current_action_s2;
	logic                         action_changed_s2;
	logic                         clear_irq_s2;
	logic [lfm_pkg::STATUS_W-1:0] item_status_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			current_action_s2 <= act_out;
			action_changed_s2 <= changed;
			clear_irq_s2      <= clear_out;
			item_status_s2    <= status_pack;
		end
	end

	assign result.valid          = valid_s2;
	assign result.current_action = current_action_s2;
	assign result.action_changed = action_changed_s2;
	assign result.clear_irq      = clear_irq_s2;
	assign result.item_status    = item_status_s2;

endmodule
